// ----- src/rrt_pkg.sv -----
package rrt_pkg;

   // Command codes of a request transaction
   typedef enum logic [1:0] {
      CMD_ROUTE      = 2'd0,
      CMD_REGISTER   = 2'd1,
      CMD_UNREGISTER = 2'd2,
      CMD_QUERY      = 2'd3
   } cmd_type;

   // Status codes of a response transaction
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   localparam int unsigned OpcodeW = 16;
   localparam int unsigned ParamW  = 32;
   localparam int unsigned ParamsW = 5 * ParamW;
   localparam int unsigned KeyW    = OpcodeW + ParamsW;
   localparam int unsigned HandlerW = 8;

   // Request transaction payload
   typedef struct packed {
      cmd_type               command;
      logic [OpcodeW-1:0]    key_opcode;
      logic [ParamW-1:0]     key_param_one;
      logic [ParamW-1:0]     key_param_two;
      logic [ParamW-1:0]     key_param_three;
      logic [ParamW-1:0]     key_param_four;
      logic [ParamW-1:0]     key_param_five;
      logic [HandlerW-1:0]   handler_in;
   } req_type;

   // Response transaction payload
   typedef struct packed {
      status_type            status;
      logic [HandlerW-1:0]   handler_out;
      logic                  opcode_present;
   } rsp_type;

   // Classified job held in the queue between front and back
   typedef struct packed {
      cmd_type               command;
      logic                  one_shot;
      logic [KeyW-1:0]       key;
      logic [HandlerW-1:0]   handler;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic not_empty;
      logic full;
   } q_stat_type;

endpackage

// ----- src/request_routing_table.sv -----
// Request routing table: maps a key (16-bit operation code plus five 32-bit
// parameters) to an 8-bit handler id, with route, register, unregister and
// query commands. A command is taken when start is high and busy is low;
// busy only rises when the two-deep command queue is full. Each command
// yields exactly one response, shown for a single cycle with rsp_valid, and
// the receiver cannot stall it. The table engine works one command at a
// time, in order through queue pop, parallel key compare across all
// entries, match/free-slot encode with handler read, and update and
// response, and pops the next queued command only after that update. The
// table is empty after reset with no clearing pass.
module request_routing_table #(
   parameter int unsigned TABLE_ENTRIES   = 16,
   parameter int unsigned ONE_SHOT_CODE_A = 4109,
   parameter int unsigned ONE_SHOT_CODE_B = 4124
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rrt_pkg::req_type req_data,
   output logic             rsp_valid,
   output rrt_pkg::rsp_type rsp_data
);
   import rrt_pkg::*;

   q_stat_type q_stat;
   job_type    push_job, head_job;
   logic       push, pop;

   rrt_front #(
      .ONE_SHOT_CODE_A(ONE_SHOT_CODE_A),
      .ONE_SHOT_CODE_B(ONE_SHOT_CODE_B)
   ) u_front (
      .start   (start),
      .req_data(req_data),
      .q_stat  (q_stat),
      .busy    (busy),
      .push    (push),
      .job     (push_job)
   );

   rrt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .head_job(head_job),
      .q_stat  (q_stat)
   );

   rrt_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .head_job (head_job),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

// ----- src/rrt_front.sv -----
module rrt_front #(
   parameter int unsigned ONE_SHOT_CODE_A = 4109,
   parameter int unsigned ONE_SHOT_CODE_B = 4124
) (
   input  logic               start,
   input  rrt_pkg::req_type   req_data,
   input  rrt_pkg::q_stat_type q_stat,
   output logic               busy,
   output logic               push,
   output rrt_pkg::job_type   job
);
   import rrt_pkg::*;

   localparam logic [OpcodeW-1:0] CodeA = OpcodeW'(ONE_SHOT_CODE_A);
   localparam logic [OpcodeW-1:0] CodeB = OpcodeW'(ONE_SHOT_CODE_B);

   // Accept whenever the queue has room
   assign busy = q_stat.full;
   assign push = start & ~q_stat.full;

   // Pack the key and flag routes that consume their entry
   always_comb begin
      job.command  = req_data.command;
      job.one_shot = (req_data.command == CMD_ROUTE) &&
                     ((req_data.key_opcode == CodeA) || (req_data.key_opcode == CodeB));
      job.key      = {req_data.key_opcode,
                      req_data.key_param_five, req_data.key_param_four,
                      req_data.key_param_three, req_data.key_param_two,
                      req_data.key_param_one};
      job.handler  = req_data.handler_in;
   end

endmodule

// ----- src/rrt_queue.sv -----
module rrt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rrt_pkg::job_type    push_job,
   input  logic                pop,
   output rrt_pkg::job_type    head_job,
   output rrt_pkg::q_stat_type q_stat
);
   import rrt_pkg::*;

   // Two-slot queue
   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_stat.full      = (count_ff == 2'd2);
   assign q_stat.not_empty = (count_ff != 2'd0);
   assign do_push  = push & ~q_stat.full;
   assign do_pop   = pop & q_stat.not_empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- src/rrt_back.sv -----
module rrt_back #(
   parameter int unsigned TABLE_ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rrt_pkg::q_stat_type q_stat,
   input  rrt_pkg::job_type    head_job,
   output logic                pop,
   output logic                rsp_valid,
   output rrt_pkg::rsp_type    rsp_data
);
   import rrt_pkg::*;

   localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CMP  = 4'b0010,
      S_SEL  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   job_type   job_ff;

   // Table cells: keys in flops compared in place, handlers in a memory
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [KeyW-1:0]          key_ff [TABLE_ENTRIES];
   logic [HandlerW-1:0]      handler_ff [TABLE_ENTRIES];
   logic [HandlerW-1:0]      hrd_ff;

   // Compare results and selections
   logic [TABLE_ENTRIES-1:0] match_ff, opm_ff, free_ff;
   logic                     hit_ff, free_any_ff, present_ff;
   logic [IdxW-1:0]          hit_idx_ff, free_idx_ff;
   logic [IdxW-1:0]          hit_idx, free_idx;

   // Update controls
   logic                     key_we, hdl_we;
   logic [IdxW-1:0]          key_wa, hdl_wa;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   assign pop       = (state_ff == S_IDLE) & q_stat.not_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Index of the single exact match, and lowest free entry
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (match_ff[i]) begin
            hit_idx = hit_idx | IdxW'(i);
         end
      end
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_idx = IdxW'(i);
         end
      end
   end

   // Sequencer and table update
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      key_we       = 1'b0;
      key_wa       = free_idx_ff;
      hdl_we       = 1'b0;
      hdl_wa       = hit_idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_stat.not_empty) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_SEL;
         end
         S_SEL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in                = S_IDLE;
            rsp_valid_in            = 1'b1;
            rsp_in.status           = ST_OK;
            rsp_in.handler_out      = '0;
            rsp_in.opcode_present   = 1'b0;
            unique case (job_ff.command)
               CMD_ROUTE: begin
                  if (hit_ff) begin
                     rsp_in.handler_out = hrd_ff;
                     if (job_ff.one_shot) begin
                        valid_in[hit_idx_ff] = 1'b0;
                     end
                  end else begin
                     rsp_in.status = ST_MISS;
                  end
               end
               CMD_REGISTER: begin
                  if (hit_ff) begin
                     hdl_we = 1'b1;
                  end else if (free_any_ff) begin
                     hdl_we                = 1'b1;
                     hdl_wa                = free_idx_ff;
                     key_we                = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end
               CMD_UNREGISTER: begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                  end else begin
                     rsp_in.status = ST_MISS;
                  end
               end
               CMD_QUERY: begin
                  rsp_in.opcode_present = present_ff;
               end
               default: begin
                  rsp_in.status = ST_OK;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (pop) begin
         job_ff <= head_job;
      end
      // Compare stage: every cell checks the key in parallel
      if (state_ff == S_CMP) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match_ff[i] <= valid_ff[i] && (key_ff[i] == job_ff.key);
            opm_ff[i]   <= valid_ff[i] &&
                           (key_ff[i][KeyW-1 -: OpcodeW] == job_ff.key[KeyW-1 -: OpcodeW]);
         end
         free_ff <= ~valid_ff;
      end
      // Select stage: encode and reduce
      if (state_ff == S_SEL) begin
         hit_ff      <= |match_ff;
         hit_idx_ff  <= hit_idx;
         free_any_ff <= |free_ff;
         free_idx_ff <= free_idx;
         present_ff  <= |opm_ff;
      end
      if (key_we) begin
         key_ff[key_wa] <= job_ff.key;
      end
   end

   // Handler memory: one read, one write port
   always_ff @(posedge clock) begin
      hrd_ff <= handler_ff[hit_idx];
      if (hdl_we) begin
         handler_ff[hdl_wa] <= job_ff.handler;
      end
   end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rrt_pkg::*;

   localparam int unsigned ENTRIES = 16;
   localparam logic [OpcodeW-1:0] SHOT_A = 16'd4109;
   localparam logic [OpcodeW-1:0] SHOT_B = 16'd4124;
   localparam int unsigned POOL_SIZE = 24;
   localparam int unsigned RANDOM_PER_PHASE = 284;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned REPORT_LIMIT = 10;

   localparam logic [KeyW-1:0] KEY_ZERO = '0;
   localparam logic [KeyW-1:0] KEY_ONES = '1;
   // same as all ones except bit 0 of param five
   localparam logic [KeyW-1:0] KEY_ONES_P5 = {{(KeyW-1){1'b1}}, 1'b0};
   // same as all ones except bit 0 of param three
   localparam logic [KeyW-1:0] KEY_ONES_P3 = KEY_ONES & ~(KeyW'(1) << 64);
   localparam logic [KeyW-1:0] KEY_SHOT_A = {SHOT_A, {ParamsW{1'b0}}};
   localparam logic [KeyW-1:0] KEY_SHOT_B = {SHOT_B, {5{32'h0F0F_F0F0}}};

   // one row of the directed stimulus
   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type answer;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // sideband carried along with each request transaction
   logic    req_typed = 1'b0;
   rsp_type req_answer = '0;

   // shadow of the routing table
   logic            tbl_valid [ENTRIES];
   logic [KeyW-1:0] tbl_key [ENTRIES];
   logic [7:0]      tbl_handler [ENTRIES];

   rsp_type         pending_responses [$];
   dir_row_type     dir_rows [$];
   logic [KeyW-1:0] key_pool [POOL_SIZE];

   int unsigned idle_pct = 0;
   int unsigned items_sent = 0;
   int unsigned responses_seen = 0;
   int unsigned quiet_cycles = 0;
   int unsigned failures = 0;
   rsp_type     table_answer;
   rsp_type     oldest;

   request_routing_table #(
      .TABLE_ENTRIES   (ENTRIES),
      .ONE_SHOT_CODE_A (SHOT_A),
      .ONE_SHOT_CODE_B (SHOT_B)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [KeyW-1:0] key_of(req_type r);
      return {r.key_opcode, r.key_param_one, r.key_param_two, r.key_param_three,
              r.key_param_four, r.key_param_five};
   endfunction

   function automatic req_type make_request(cmd_type c, logic [KeyW-1:0] k, logic [7:0] h);
      req_type r;
      r.command = c;
      {r.key_opcode, r.key_param_one, r.key_param_two, r.key_param_three,
       r.key_param_four, r.key_param_five} = k;
      r.handler_in = h;
      return r;
   endfunction

   function automatic logic [KeyW-1:0] random_key();
      return {16'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
              32'($urandom), 32'($urandom)};
   endfunction

   function automatic dir_row_type dir_row(cmd_type c, logic [KeyW-1:0] k, logic [7:0] h,
                                           logic typed, status_type s, logic [7:0] hout,
                                           logic present);
      dir_row_type d;
      d.req = make_request(c, k, h);
      d.typed = typed;
      d.answer.status = s;
      d.answer.handler_out = hout;
      d.answer.opcode_present = present;
      return d;
   endfunction

   // Works out the response of one command and updates the shadow table
   function automatic rsp_type routing_outcome(req_type r);
      rsp_type         a;
      logic [KeyW-1:0] k;
      int              hit;
      int              slot;
      a = '0;
      a.status = ST_OK;
      k = key_of(r);
      hit = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
      case (r.command)
         CMD_ROUTE: begin
            if (hit < 0) begin
               a.status = ST_MISS;
            end else begin
               a.handler_out = tbl_handler[hit];
               if (r.key_opcode == SHOT_A || r.key_opcode == SHOT_B) tbl_valid[hit] = 1'b0;
            end
         end
         CMD_REGISTER: begin
            slot = hit;
            if (slot < 0) begin
               // lowest free entry takes a new key
               for (int i = 0; i < ENTRIES; i++)
                  if (slot < 0 && !tbl_valid[i]) slot = i;
               if (slot >= 0) begin
                  tbl_valid[slot] = 1'b1;
                  tbl_key[slot] = k;
               end
            end
            if (slot < 0) a.status = ST_FULL;
            else tbl_handler[slot] = r.handler_in;
         end
         CMD_UNREGISTER: begin
            if (hit < 0) a.status = ST_MISS;
            else tbl_valid[hit] = 1'b0;
         end
         CMD_QUERY: begin
            for (int i = 0; i < ENTRIES; i++)
               if (tbl_valid[i] && tbl_key[i][KeyW-1 -: OpcodeW] == r.key_opcode)
                  a.opcode_present = 1'b1;
         end
      endcase
      return a;
   endfunction

   function automatic void log_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
   endfunction

   // Random command: mostly keys from the pool, some noise keys
   function automatic req_type random_request(int unsigned reg_pct);
      logic [KeyW-1:0] k;
      int unsigned     roll;
      int unsigned     rest;
      cmd_type         c;
      roll = $urandom_range(99);
      rest = 100 - reg_pct;
      if (roll < reg_pct) c = CMD_REGISTER;
      else if (roll < reg_pct + rest * 4 / 10) c = CMD_ROUTE;
      else if (roll < reg_pct + rest * 7 / 10) c = CMD_UNREGISTER;
      else c = CMD_QUERY;
      if ($urandom_range(9) == 0) k = random_key();
      else k = key_pool[$urandom_range(POOL_SIZE-1)];
      if (c == CMD_QUERY && $urandom_range(3) == 0) k[KeyW-1 -: OpcodeW] = 16'($urandom);
      return make_request(c, k, 8'($urandom));
   endfunction

   // Drive one request transaction; returns at the edge that accepts it
   task automatic send_request(req_type r, logic typed, rsp_type answer);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      req_typed <= typed;
      req_answer <= answer;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // Hold off the sender until every response has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (responses_seen < items_sent) @(posedge clock);
   endtask

   // Response check, shadow update on accept, and quiet-cycle watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            responses_seen++;
            if (pending_responses.size() == 0) begin
               log_failure($sformatf("unexpected response status=%0d handler=%h present=%b",
                                     rsp_data.status, rsp_data.handler_out,
                                     rsp_data.opcode_present));
            end else begin
               oldest = pending_responses.pop_front();
               if (rsp_data.status !== oldest.status ||
                   rsp_data.handler_out !== oldest.handler_out ||
                   rsp_data.opcode_present !== oldest.opcode_present)
                  log_failure($sformatf({"MISMATCH status exp %0d got %0d, handler exp %h ",
                                         "got %h, present exp %b got %b"},
                                        oldest.status, rsp_data.status,
                                        oldest.handler_out, rsp_data.handler_out,
                                        oldest.opcode_present, rsp_data.opcode_present));
            end
         end
         if (start && !busy) begin
            table_answer = routing_outcome(req_data);
            pending_responses.push_back(req_typed ? req_answer : table_answer);
         end
         if (rsp_valid || (start && !busy)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      logic [KeyW-1:0] k;
      int unsigned     reg_pct;

      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;

      // key pool: random keys, one-shot codes, one-bit neighbors, shared opcodes
      for (int i = 0; i < POOL_SIZE; i++) begin
         k = random_key();
         case (i % 6)
            1: k[KeyW-1 -: OpcodeW] = SHOT_A;
            2: k[KeyW-1 -: OpcodeW] = SHOT_B;
            3: k = key_pool[i-1] ^ (KeyW'(1) << $urandom_range(KeyW-1));
            4: k[KeyW-1 -: OpcodeW] = key_pool[i-1][KeyW-1 -: OpcodeW];
            default: ;
         endcase
         key_pool[i] = k;
      end

      // directed stimulus
      dir_rows.push_back(dir_row(CMD_ROUTE,      KEY_ZERO,    8'h00, 1, ST_MISS, 8'h00, 0));
      dir_rows.push_back(dir_row(CMD_QUERY,      KEY_ZERO,    8'h00, 1, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_UNREGISTER, KEY_ZERO,    8'h00, 1, ST_MISS, 8'h00, 0));
      dir_rows.push_back(dir_row(CMD_REGISTER,   KEY_ONES,    8'hFF, 1, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_ROUTE,      KEY_ONES,    8'h00, 1, ST_OK,   8'hFF, 0));
      dir_rows.push_back(dir_row(CMD_QUERY,      KEY_ONES,    8'h00, 1, ST_OK,   8'h00, 1));
      // overwrite of a present key
      dir_rows.push_back(dir_row(CMD_REGISTER,   KEY_ONES,    8'h00, 1, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_ROUTE,      KEY_ONES,    8'hFF, 1, ST_OK,   8'h00, 0));
      // keys one bit away from a stored key
      dir_rows.push_back(dir_row(CMD_REGISTER,   KEY_ONES_P5, 8'h3C, 0, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_ROUTE,      KEY_ONES_P3, 8'h00, 0, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_ROUTE,      KEY_ONES_P5, 8'h00, 0, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_REGISTER,   KEY_ZERO,    8'h81, 1, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_QUERY,      KEY_ZERO,    8'h00, 1, ST_OK,   8'h00, 1));
      // one-shot route removes the entry it hits
      dir_rows.push_back(dir_row(CMD_REGISTER,   KEY_SHOT_A,  8'h5A, 1, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_QUERY,      KEY_SHOT_A,  8'h00, 1, ST_OK,   8'h00, 1));
      dir_rows.push_back(dir_row(CMD_ROUTE,      KEY_SHOT_A,  8'h00, 1, ST_OK,   8'h5A, 0));
      dir_rows.push_back(dir_row(CMD_ROUTE,      KEY_SHOT_A,  8'h00, 1, ST_MISS, 8'h00, 0));
      // one-shot code on register has no special effect
      dir_rows.push_back(dir_row(CMD_REGISTER,   KEY_SHOT_B,  8'hA5, 1, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_REGISTER,   KEY_SHOT_B,  8'hC3, 1, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_ROUTE,      KEY_SHOT_B,  8'h00, 1, ST_OK,   8'hC3, 0));
      dir_rows.push_back(dir_row(CMD_QUERY,      KEY_SHOT_B,  8'h00, 1, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_UNREGISTER, KEY_ONES,    8'h00, 1, ST_OK,   8'h00, 0));
      dir_rows.push_back(dir_row(CMD_ROUTE,      KEY_ONES,    8'h00, 1, ST_MISS, 8'h00, 0));
      dir_rows.push_back(dir_row(CMD_UNREGISTER, KEY_ONES,    8'h00, 1, ST_MISS, 8'h00, 0));
      dir_rows.push_back(dir_row(CMD_ROUTE,      KEY_ZERO,    8'h00, 0, ST_OK,   8'h00, 0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 19;
      foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].answer);
      drain();

      // random phases: sender idles 19%, then 55%, then never
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 19 : (ph == 1) ? 55 : 0;
         reg_pct = (ph == 0) ? 45 : (ph == 1) ? 35 : 30;
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_request(random_request(reg_pct), 1'b0, '0);
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_responses.size() != 0)
         log_failure($sformatf("%0d responses never arrived", pending_responses.size()));
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/rrt_pkg.sv
src/rrt_front.sv
src/rrt_queue.sv
src/rrt_back.sv
src/request_routing_table.sv
tb/sv/tb.sv
